FILE: rtl/apcc_pkg.sv
package apcc_pkg;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	localparam logic [1:0] AXIS_E = 2'd0;
	localparam logic [1:0] AXIS_N = 2'd1;
	localparam logic [1:0] AXIS_U = 2'd2;

	localparam int SC_LAT = 14;

	localparam logic [31:0] PI_Q30     = 32'd3373259426;
	localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
	localparam logic [17:0] ZEN_90     = 18'd16384;
	localparam logic [6:0]  GRID_SCALE = 7'd72;

	localparam logic [5:0] D42 = 6'd42;
	localparam logic [5:0] D56 = 6'd56;
	localparam logic [5:0] D20 = 6'd20;
	localparam logic [5:0] D30 = 6'd30;
	localparam logic [5:0] D6  = 6'd6;
	localparam logic [5:0] D12 = 6'd12;

	localparam logic [30:0] RCP_42 = 31'((64'd1 << 31) / 42);
	localparam logic [30:0] RCP_56 = 31'((64'd1 << 31) / 56);
	localparam logic [30:0] RCP_20 = 31'((64'd1 << 31) / 20);
	localparam logic [30:0] RCP_30 = 31'((64'd1 << 31) / 30);
	localparam logic [30:0] RCP_6  = 31'((64'd1 << 31) / 6);
	localparam logic [30:0] RCP_12 = 31'((64'd1 << 31) / 12);

	typedef struct packed {
		logic               op;
		logic [6:0]         idx;
		logic signed [23:0] value;
		logic signed [15:0] el;
		logic signed [23:0] de;
		logic signed [23:0] dn;
		logic signed [23:0] du;
		logic               use_var;
	} item_t;

	typedef struct packed {
		logic               off_we;
		logic               var_we;
		logic [1:0]         lane;
		logic signed [23:0] data;
	} tbl_wr_t;

	function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
		logic [61:0] p;
		p = {31'b0, a} * {31'b0, b};
		return p[60:30];
	endfunction

	function automatic logic [30:0] rcp_est(input logic [30:0] n, input logic [30:0] m);
		logic [61:0] p;
		p = {31'b0, n} * {31'b0, m};
		return p[61:31];
	endfunction

	function automatic logic [30:0] rcp_fix(input logic [30:0] n, input logic [30:0] qa,
			input logic [5:0] d);
		logic [36:0] qd;
		logic [30:0] r;
		qd = {6'b0, qa} * {31'b0, d};
		r = n - qd[30:0];
		return (r >= {25'b0, d}) ? qa + 31'd1 : qa;
	endfunction

endpackage

FILE: rtl/apcc_if.sv
interface apcc_cmd_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic [6:0]         table_index;
	logic signed [23:0] table_value;
	logic [15:0]        azimuth;
	logic signed [15:0] elevation;
	logic signed [23:0] del_east;
	logic signed [23:0] del_north;
	logic signed [23:0] del_up;
	logic               use_variation;

	modport source (output valid, operation, table_index, table_value, azimuth, elevation,
		del_east, del_north, del_up, use_variation, input ready);
	modport sink (input valid, operation, table_index, table_value, azimuth, elevation,
		del_east, del_north, del_up, use_variation, output ready);
endinterface

interface apcc_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         freq_index;
	logic signed [31:0] correction;
	logic               last;

	modport source (output valid, freq_index, correction, last, input ready);
	modport sink (input valid, freq_index, correction, last, output ready);
endinterface

FILE: rtl/apcc_sincos.sv
module apcc_sincos (
	input  logic               clk,
	input  logic               en,
	input  logic [15:0]        angle,
	output logic signed [31:0] sin_v,
	output logic signed [31:0] cos_v
);
	import apcc_pkg::*;

	logic [13:0] r_in;
	logic        swap;
	logic [13:0] t;
	logic [45:0] xp;
	logic [30:0] xx;
	logic [30:0] sr;
	logic [30:0] cr;
	logic signed [31:0] srs;
	logic signed [31:0] crs;

	logic [13:0] t_s1;
	logic [1:0]  q_s [1:13];
	logic        sw_s [1:13];
	logic [29:0] x_s [2:11];
	logic [29:0] x2_s [3:11];
	logic [30:0] sq_s4, cq_s4, sp_s5, cp_s5, sn_s6, cn_s6;
	logic [30:0] sq_s7, cq_s7, sn_s7, cn_s7, sp_s8, cp_s8, sn_s9, cn_s9;
	logic [30:0] sq_s10, cq_s10, sn_s10, cn_s10, sp_s11, cp_s11;
	logic [30:0] sv_s12, cn_s12, sv_s13, cv_s13;
	logic signed [31:0] sin_s14, cos_s14;

	always_comb begin
		r_in = angle[13:0];
		swap = r_in > 14'd8192;
		t = swap ? 14'(15'd16384 - {1'b0, r_in}) : r_in;
		xp = {32'b0, t_s1} * {14'b0, PI_Q30};
		xx = mul_q30({1'b0, x_s[2]}, {1'b0, x_s[2]});
		sr = sw_s[13] ? cv_s13 : sv_s13;
		cr = sw_s[13] ? sv_s13 : cv_s13;
		srs = $signed({1'b0, sr});
		crs = $signed({1'b0, cr});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t;
			q_s[1] <= angle[15:14];
			sw_s[1] <= swap;
			for (int k = 2; k <= 13; k++) begin
				q_s[k] <= q_s[k-1];
				sw_s[k] <= sw_s[k-1];
			end
			x_s[2] <= xp[44:15];
			for (int k = 3; k <= 11; k++)
				x_s[k] <= x_s[k-1];
			x2_s[3] <= xx[29:0];
			for (int k = 4; k <= 11; k++)
				x2_s[k] <= x2_s[k-1];

			sq_s4 <= rcp_est({1'b0, x2_s[3]}, RCP_42);
			cq_s4 <= rcp_est({1'b0, x2_s[3]}, RCP_56);
			sp_s5 <= Q30_ONE - rcp_fix({1'b0, x2_s[4]}, sq_s4, D42);
			cp_s5 <= Q30_ONE - rcp_fix({1'b0, x2_s[4]}, cq_s4, D56);
			sn_s6 <= mul_q30({1'b0, x2_s[5]}, sp_s5);
			cn_s6 <= mul_q30({1'b0, x2_s[5]}, cp_s5);

			sq_s7 <= rcp_est(sn_s6, RCP_20);
			cq_s7 <= rcp_est(cn_s6, RCP_30);
			sn_s7 <= sn_s6;
			cn_s7 <= cn_s6;
			sp_s8 <= Q30_ONE - rcp_fix(sn_s7, sq_s7, D20);
			cp_s8 <= Q30_ONE - rcp_fix(cn_s7, cq_s7, D30);
			sn_s9 <= mul_q30({1'b0, x2_s[8]}, sp_s8);
			cn_s9 <= mul_q30({1'b0, x2_s[8]}, cp_s8);

			sq_s10 <= rcp_est(sn_s9, RCP_6);
			cq_s10 <= rcp_est(cn_s9, RCP_12);
			sn_s10 <= sn_s9;
			cn_s10 <= cn_s9;
			sp_s11 <= Q30_ONE - rcp_fix(sn_s10, sq_s10, D6);
			cp_s11 <= Q30_ONE - rcp_fix(cn_s10, cq_s10, D12);

			sv_s12 <= mul_q30({1'b0, x_s[11]}, sp_s11);
			cn_s12 <= mul_q30({1'b0, x2_s[11]}, cp_s11);
			sv_s13 <= sv_s12;
			cv_s13 <= Q30_ONE - (cn_s12 >> 1);

			case (q_s[13])
				2'd0: begin sin_s14 <= srs; cos_s14 <= crs; end
				2'd1: begin sin_s14 <= crs; cos_s14 <= -srs; end
				2'd2: begin sin_s14 <= -srs; cos_s14 <= -crs; end
				default: begin sin_s14 <= -crs; cos_s14 <= srs; end
			endcase
		end
	end

	assign sin_v = sin_s14;
	assign cos_v = cos_s14;

endmodule

FILE: rtl/apcc_tables.sv
module apcc_tables #(
	parameter int NUM_FREQ = 3,
	parameter int GRID_POINTS = 19,
	localparam int RW = (NUM_FREQ > 1) ? $clog2(NUM_FREQ) : 1,
	localparam int VAR_WORDS = NUM_FREQ * GRID_POINTS,
	localparam int VW = $clog2(VAR_WORDS)
) (
	input  logic                clk,
	input  apcc_pkg::tbl_wr_t   wr,
	input  logic [RW-1:0]       wr_row,
	input  logic [VW-1:0]       wr_addr,
	input  logic                rd_en,
	input  logic [RW-1:0]       rd_row,
	input  logic [VW-1:0]       rd_a0,
	input  logic [VW-1:0]       rd_a1,
	output logic signed [23:0]  off_e,
	output logic signed [23:0]  off_n,
	output logic signed [23:0]  off_u,
	output logic signed [23:0]  var0,
	output logic signed [23:0]  var1
);
	import apcc_pkg::*;

	logic [2:0][23:0] off_mem_q [NUM_FREQ];
	logic [23:0]      var_mem_q [VAR_WORDS];
	logic [2:0][23:0] off_rd_q;
	logic [23:0]      var0_q;
	logic [23:0]      var1_q;

	always_ff @(posedge clk) begin
		if (wr.off_we)
			off_mem_q[wr_row][wr.lane] <= wr.data;
		if (wr.var_we)
			var_mem_q[wr_addr] <= wr.data;
		if (rd_en) begin
			off_rd_q <= off_mem_q[rd_row];
			var0_q <= var_mem_q[rd_a0];
			var1_q <= var_mem_q[rd_a1];
		end
	end

	assign off_e = $signed(off_rd_q[AXIS_E]);
	assign off_n = $signed(off_rd_q[AXIS_N]);
	assign off_u = $signed(off_rd_q[AXIS_U]);
	assign var0 = $signed(var0_q);
	assign var1 = $signed(var1_q);

endmodule

FILE: rtl/antenna_phase_center_correction_core.sv
// Antenna phase-centre correction core.
// cmd carries requests: operation 0 writes one table word (offsets E/N/U per
// frequency, then the zenith variation grid per frequency); operation 1 asks for
// corrections at the given azimuth and elevation. A compute request yields one
// result on res per frequency, in frequency order, last set on the final one.
// A write request yields no result and takes effect in request order.
// A compute request passes through the 14-stage sine/cosine pipeline, the head
// register, the table read, the multiply, the sum and the output register.
// The head sequencer issues one table read per frequency of a compute request,
// one per cycle while the back stages can take it; a write needs no table read.
// Reset clears all valid state; table contents are undefined until written.
// When res stalls, the result holds in the output register and the back stages
// fill up; cmd.ready drops while the head sequencer has frequencies of a compute
// request left to issue, or when it cannot issue.
module antenna_phase_center_correction_core #(
	parameter int NUM_FREQ = 3,
	parameter int GRID_POINTS = 19
) (
	input logic       clk,
	input logic       arst_n,
	apcc_cmd_if.sink  cmd,
	apcc_res_if.source res
);
	import apcc_pkg::*;

	localparam int OFF_WORDS = 3 * NUM_FREQ;
	localparam int VAR_WORDS = NUM_FREQ * GRID_POINTS;
	localparam int FW = (NUM_FREQ > 1) ? $clog2(NUM_FREQ) : 1;
	localparam int IW = $clog2(GRID_POINTS);
	localparam int VW = $clog2(VAR_WORDS);

	item_t              cur;
	item_t              line_q [SC_LAT];
	logic               line_v_q [SC_LAT];
	logic signed [31:0] az_s, az_c, el_s, el_c;

	logic               h_take, h_done, issue, rd_en;
	logic               en1, en2, en3, en_o;
	logic               hv_q, hop_q, huse_q;
	logic [6:0]         hidx_q;
	logic signed [23:0] hval_q, hde_q, hdn_q, hdu_q;
	logic signed [31:0] e0_q, e1_q, e2_q;
	logic [IW-1:0]      hi0_q, hi1_q;
	logic [15:0]        hw_q;
	logic [FW-1:0]      f_q;

	logic signed [63:0] pe0, pe1;
	logic signed [17:0] zen;
	logic [22:0]        g;
	logic [6:0]         gi;
	logic [IW-1:0]      i0, i1;
	logic [15:0]        w;

	tbl_wr_t            wr;
	logic [FW-1:0]      wr_row;
	logic [1:0]         wr_lane;
	logic [VW-1:0]      wr_addr, rd_a0, rd_a1;
	logic               in_off, in_var;
	logic signed [23:0] off_e, off_n, off_u, var0, var1;

	logic               v_s1, v_s2, v_s3;
	logic               last_s1, last_s2, last_s3, use_s1, use_s2;
	logic [FW-1:0]      f_s1, f_s2, f_s3;
	logic signed [31:0] e0_s1, e1_s1, e2_s1;
	logic signed [23:0] de_s1, dn_s1, du_s1;
	logic [15:0]        w_s1;
	logic signed [56:0] m0_s2, m1_s2, m2_s2;
	logic signed [41:0] vp0_s2, vp1_s2;
	logic signed [28:0] dot_s3;
	logic signed [26:0] var_s3;

	logic signed [24:0] a0, a1, a2;
	logic [16:0]        wc;
	logic signed [58:0] dsum;
	logic signed [42:0] vsum;
	logic signed [33:0] corr;

	logic               out_v_q, out_last_q;
	logic [FW-1:0]      out_f_q;
	logic signed [31:0] out_corr_q;

	assign cur = '{op: cmd.operation, idx: cmd.table_index, value: cmd.table_value,
		el: cmd.elevation, de: cmd.del_east, dn: cmd.del_north, du: cmd.del_up,
		use_var: cmd.use_variation};

	apcc_sincos u_az (.clk(clk), .en(h_take), .angle(cmd.azimuth), .sin_v(az_s), .cos_v(az_c));
	apcc_sincos u_el (.clk(clk), .en(h_take), .angle(cmd.elevation), .sin_v(el_s),
		.cos_v(el_c));

	assign en_o = !out_v_q || res.ready;
	assign en3 = !v_s3 || en_o;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign h_done = (hop_q == OP_WRITE) || (f_q == FW'(NUM_FREQ - 1));
	assign issue = hv_q && ((hop_q == OP_WRITE) || en1);
	assign h_take = !hv_q || (h_done && issue);
	assign rd_en = issue && (hop_q == OP_COMPUTE);
	assign cmd.ready = h_take;

	always_comb begin
		pe0 = az_s * el_c;
		pe1 = az_c * el_c;
		zen = $signed(ZEN_90) - 18'(line_q[SC_LAT-1].el);
		g = 23'(zen[16:0]) * {16'b0, GRID_SCALE};
		gi = g[22:16];
		i0 = IW'(gi);
		w = g[15:0];
		if (zen < 0) begin
			i0 = '0;
			w = '0;
		end else if (gi >= 7'(GRID_POINTS - 1)) begin
			i0 = IW'(GRID_POINTS - 1);
			w = '0;
		end
		i1 = (w == 16'd0) ? i0 : i0 + IW'(1);
	end

	always_comb begin
		wr_row = '0;
		wr_lane = AXIS_E;
		for (int r = 0; r < NUM_FREQ; r++) begin
			if (int'(hidx_q) >= 3 * r) begin
				wr_row = FW'(r);
				wr_lane = 2'(int'(hidx_q) - 3 * r);
			end
		end
		in_off = int'(hidx_q) < OFF_WORDS;
		in_var = !in_off && (int'(hidx_q) < OFF_WORDS + VAR_WORDS);
		wr_addr = VW'(int'(hidx_q) - OFF_WORDS);
		wr.off_we = issue && (hop_q == OP_WRITE) && in_off;
		wr.var_we = issue && (hop_q == OP_WRITE) && in_var;
		wr.lane = wr_lane;
		wr.data = hval_q;
		rd_a0 = VW'(int'(f_q) * GRID_POINTS + int'(hi0_q));
		rd_a1 = VW'(int'(f_q) * GRID_POINTS + int'(hi1_q));
	end

	apcc_tables #(.NUM_FREQ(NUM_FREQ), .GRID_POINTS(GRID_POINTS)) u_tables (
		.clk(clk), .wr(wr), .wr_row(wr_row), .wr_addr(wr_addr), .rd_en(rd_en),
		.rd_row(f_q), .rd_a0(rd_a0), .rd_a1(rd_a1), .off_e(off_e), .off_n(off_n),
		.off_u(off_u), .var0(var0), .var1(var1));

	always_comb begin
		a0 = 25'(off_e) + 25'(de_s1);
		a1 = 25'(off_n) + 25'(dn_s1);
		a2 = 25'(off_u) + 25'(du_s1);
		wc = 17'h10000 - {1'b0, w_s1};
		dsum = 59'(m0_s2) + 59'(m1_s2) + 59'(m2_s2) + 59'sd536870912;
		vsum = 43'(vp0_s2) + 43'(vp1_s2) + 43'sd32768;
		corr = 34'(var_s3) - 34'(dot_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SC_LAT; k++)
				line_v_q[k] <= 1'b0;
			hv_q <= 1'b0;
			f_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (h_take) begin
				line_v_q[0] <= cmd.valid;
				for (int k = 1; k < SC_LAT; k++)
					line_v_q[k] <= line_v_q[k-1];
				hv_q <= line_v_q[SC_LAT-1];
			end
			if (rd_en)
				f_q <= h_done ? '0 : f_q + FW'(1);
			if (en1)
				v_s1 <= rd_en;
			if (en2)
				v_s2 <= v_s1;
			if (en3)
				v_s3 <= v_s2;
			if (en_o)
				out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (h_take) begin
			line_q[0] <= cur;
			for (int k = 1; k < SC_LAT; k++)
				line_q[k] <= line_q[k-1];
			hop_q <= line_q[SC_LAT-1].op;
			hidx_q <= line_q[SC_LAT-1].idx;
			hval_q <= line_q[SC_LAT-1].value;
			hde_q <= line_q[SC_LAT-1].de;
			hdn_q <= line_q[SC_LAT-1].dn;
			hdu_q <= line_q[SC_LAT-1].du;
			huse_q <= line_q[SC_LAT-1].use_var;
			e0_q <= 32'((pe0 + 64'sd536870912) >>> 30);
			e1_q <= 32'((pe1 + 64'sd536870912) >>> 30);
			e2_q <= el_s;
			hi0_q <= i0;
			hi1_q <= i1;
			hw_q <= w;
		end
		if (en1) begin
			f_s1 <= f_q;
			last_s1 <= (f_q == FW'(NUM_FREQ - 1));
			use_s1 <= huse_q;
			e0_s1 <= e0_q;
			e1_s1 <= e1_q;
			e2_s1 <= e2_q;
			de_s1 <= hde_q;
			dn_s1 <= hdn_q;
			du_s1 <= hdu_q;
			w_s1 <= hw_q;
		end
		if (en2) begin
			f_s2 <= f_s1;
			last_s2 <= last_s1;
			use_s2 <= use_s1;
			m0_s2 <= 57'(a0) * 57'(e0_s1);
			m1_s2 <= 57'(a1) * 57'(e1_s1);
			m2_s2 <= 57'(a2) * 57'(e2_s1);
			vp0_s2 <= 42'(var0) * $signed({25'b0, wc});
			vp1_s2 <= 42'(var1) * $signed({26'b0, w_s1});
		end
		if (en3) begin
			f_s3 <= f_s2;
			last_s3 <= last_s2;
			dot_s3 <= 29'(dsum >>> 30);
			var_s3 <= use_s2 ? 27'(vsum >>> 16) : 27'sd0;
		end
		if (en_o) begin
			out_f_q <= f_s3;
			out_last_q <= last_s3;
			if (corr > 34'sd2147483647)
				out_corr_q <= 32'sh7FFF_FFFF;
			else if (corr < -34'sd2147483648)
				out_corr_q <= 32'sh8000_0000;
			else
				out_corr_q <= 32'(corr);
		end
	end

	assign res.valid = out_v_q;
	assign res.freq_index = 2'(out_f_q);
	assign res.correction = out_corr_q;
	assign res.last = out_last_q;

`ifndef SYNTHESIS
	a_last_freq: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_last_q |-> out_f_q == FW'(NUM_FREQ - 1))
		else $error("last flag on wrong frequency");
	a_rw_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && (wr.off_we || wr.var_we)))
		else $error("table read and write in one cycle");
	a_freq_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(f_q) < NUM_FREQ)
		else $error("frequency counter out of range");
	a_hold_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hv_q && hop_q == OP_COMPUTE && f_q != FW'(NUM_FREQ - 1) |-> !cmd.ready)
		else $error("request taken while sequencer busy");
`endif

endmodule
